/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, muted while reset is low.
`define ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, muted while reset is low.
`define ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

/* rtl/tetl_pkg.sv */
`default_nettype none
package tetl_pkg;

  localparam int TIME_W     = 48;
  localparam int PERIOD_W   = 32;
  localparam int SEC_W      = 29;
  localparam int US_W       = 20;
  localparam int IDX_W      = 6;
  localparam int CNT_OUT_W  = 7;
  localparam int DIV_STEP_W = 6;

  // Seconds split: product width and remainder width before the fix-up
  localparam int PROD_W  = 61;
  localparam int SPLIT_W = 21;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd500000;
  localparam logic [PERIOD_W-1:0] US_PER_SEC   = 32'd1000000;

  // floor(2^48 / 1000000); applied to the upper 32 time bits, it estimates
  // the seconds at most one low
  localparam logic [SEC_W-1:0] SEC_RECIP = 29'd281474976;

  // Request action codes
  localparam logic [1:0] ACT_RECORD = 2'd0;
  localparam logic [1:0] ACT_READ   = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  // Configuration register index
  localparam logic REG_PERIOD = 1'b0;

  typedef struct packed {
    logic [SEC_W-1:0] sec;
    logic [US_W-1:0]  us;
  } stamp_t;

  typedef struct packed {
    logic clear;
    logic wr_en;
    logic rd_en;
  } ring_cmd_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] count7;
    logic                 hit;
  } ring_stat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

/* rtl/tetl_div.sv */
`default_nettype none
module tetl_div (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire  [tetl_pkg::TIME_W-1:0]   dividend,
  input  wire  [tetl_pkg::PERIOD_W-1:0] divisor,
  output tetl_pkg::div_stat_t           stat,
  output logic [tetl_pkg::TIME_W-1:0]   quot
);
  import tetl_pkg::*;

  logic [TIME_W-1:0]     quo_r, quo_nxt;
  logic [PERIOD_W-1:0]   rem_r, rem_nxt;
  logic [PERIOD_W-1:0]   dvs_r;
  logic [DIV_STEP_W-1:0] cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [PERIOD_W:0]     trial;
  logic [PERIOD_W:0]     diff;
  logic                  fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, quo_r[TIME_W-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = (trial >= {1'b0, dvs_r});
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = DIV_STEP_W'(TIME_W);
    end else if (cnt_r != '0) begin
      quo_nxt  = {quo_r[TIME_W-2:0], fits};
      rem_nxt  = fits ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == DIV_STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quot      = quo_r;

endmodule
`default_nettype wire

/* rtl/tetl_ring.sv */
`default_nettype none
`include "assert_macros.svh"
module tetl_ring #(
  parameter int DEPTH = 64
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  tetl_pkg::ring_cmd_t          cmd,
  input  tetl_pkg::stamp_t             wr_data,
  input  wire  [tetl_pkg::IDX_W-1:0]   rd_idx,
  output tetl_pkg::ring_stat_t         stat,
  output tetl_pkg::stamp_t             rd_data
);
  import tetl_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > IDX_W + 1) ? CW : IDX_W + 1) + 1;

  stamp_t          mem [DEPTH];
  stamp_t          rd_data_r;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            hit_r;
  logic [XW-1:0]   idx_x, cnt_x, tmp, pos_x;
  logic            hit;
  logic [AW-1:0]   rd_addr;

  // Locate the slot at the requested age, newest first
  always_comb begin
    idx_x = XW'(rd_idx);
    cnt_x = XW'(count_r);
    hit   = (idx_x < cnt_x);
    tmp   = XW'(wp_r) + XW'(DEPTH - 1) - idx_x;
    pos_x = (tmp >= XW'(DEPTH)) ? tmp - XW'(DEPTH) : tmp;
    rd_addr = hit ? pos_x[AW-1:0] : '0;
  end

  // Advance the write pointer and saturate the count
  always_comb begin
    wp_nxt    = wp_r;
    count_nxt = count_r;
    if (cmd.clear) begin
      wp_nxt    = '0;
      count_nxt = '0;
    end else if (cmd.wr_en) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (count_r != CW'(DEPTH)) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      count_r <= '0;
    end else begin
      wp_r    <= wp_nxt;
      count_r <= count_nxt;
    end
  end

  // Ring storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en && !cmd.clear) begin
      mem[wp_r] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
      hit_r     <= hit;
    end
  end

  assign stat.count7 = CNT_OUT_W'(count_r);
  assign stat.hit    = hit_r;
  assign rd_data     = rd_data_r;

  `ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH))
  `ASSERT_IMP(a_wp_bound, clk, rst_n, 1'b1, wp_r <= AW'(DEPTH - 1))
  `ASSERT_NXT(a_clear_empties, clk, rst_n, cmd.clear, count_r == '0 && wp_r == '0)

endmodule
`default_nettype wire

/* rtl/throttled_event_timestamp_log_unit.sv */
// Channel   | Handshake                  | Payload
// in_       | in_valid / in_ready        | action, channel, detected, time_us, index
// out_      | out_valid / out_ready      | ok, seconds, microseconds, record_count, kind
// config    | psel, penable, pwrite ...  | window length register at byte address 0
//
// One request at a time; the next is taken the cycle after the result is loaded.
// A detected record gives its result once a 48-step bit-serial divide of time by the
// window length ends; the seconds split settles before the divide ends. A read steps
// through address, memory read and stage; a clear through a clear state; others go to output.
// Reset (rst_n low, synchronous) empties both rings and the window state.
// A result waiting on out_ready does not block the next request from being accepted.
`default_nettype none
`include "assert_macros.svh"
module throttled_event_timestamp_log_unit #(
  parameter int HUMAN_DEPTH = 64,
  parameter int CAT_DEPTH   = 64
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire  [1:0]                     in_action,
  input  wire                            in_channel,
  input  wire                            in_detected,
  input  wire  [tetl_pkg::TIME_W-1:0]    in_time_us,
  input  wire  [tetl_pkg::IDX_W-1:0]     in_index,
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic                           out_ok,
  output logic [tetl_pkg::SEC_W-1:0]     out_seconds,
  output logic [tetl_pkg::US_W-1:0]      out_microseconds,
  output logic [tetl_pkg::CNT_OUT_W-1:0] out_record_count,
  output logic                           out_kind,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [2:0]                     paddr,
  input  wire  [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import tetl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_RD, S_RDW, S_CLR, S_OUT
  } state_t;

  state_t              state_r, state_nxt;
  logic [PERIOD_W-1:0] period_r;
  logic                ch_r;
  logic [IDX_W-1:0]    idx_r;
  logic [TIME_W-1:0]   last_win_r [2];
  logic [TIME_W-1:0]   last_win_nxt [2];
  logic [1:0]          taken_r, taken_nxt;
  logic                res_ok_r, res_ok_nxt;
  stamp_t              res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r, out_ok_nxt;
  stamp_t              out_stamp_r, out_stamp_nxt;
  logic [CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic                out_kind_r, out_kind_nxt;

  logic [TIME_W-1:0]   split_t_r;
  logic [SEC_W-1:0]    split_qe_r;
  logic [TIME_W-1:0]   split_qm_r;
  logic [SPLIT_W-1:0]  split_diff_r;
  logic [SEC_W-1:0]    split_sec_r;
  logic [US_W-1:0]     split_us_r;

  logic                accept_in;
  logic                div_start;
  logic [PERIOD_W-1:0] win_divisor;
  div_stat_t           win_stat;
  logic [TIME_W-1:0]   win_quot;
  ring_cmd_t           hum_cmd, cat_cmd;
  ring_stat_t          hum_stat, cat_stat;
  stamp_t              hum_data, cat_data;
  stamp_t              new_stamp;
  ring_stat_t          sel_stat;
  stamp_t              sel_data;
  logic                new_win;
  logic                rec_ok;

  // Configuration register
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_PERIOD) begin
      period_r <= pwdata;
    end
  end
  assign prdata = (paddr[2] == REG_PERIOD) ? period_r : '0;

  assign in_ready    = (state_r == S_IDLE);
  assign accept_in   = in_valid && in_ready;
  assign div_start   = accept_in && in_action == ACT_RECORD && in_detected;
  assign win_divisor = (period_r == '0) ? PERIOD_W'(1) : period_r;

  tetl_div u_win_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(in_time_us),
    .divisor(win_divisor), .stat(win_stat), .quot(win_quot)
  );

  // Split the time into seconds and microseconds: estimate the seconds from the
  // upper time bits, take the remainder, then fix an estimate that is one low
  always_ff @(posedge clk) begin
    if (div_start) begin
      split_t_r <= in_time_us;
    end
    split_qe_r   <= SEC_W'((PROD_W'(split_t_r[TIME_W-1:16]) * PROD_W'(SEC_RECIP)) >> 32);
    split_qm_r   <= TIME_W'(split_qe_r) * TIME_W'(US_PER_SEC);
    split_diff_r <= SPLIT_W'(split_t_r - split_qm_r);
    if (split_diff_r >= SPLIT_W'(US_PER_SEC)) begin
      split_sec_r <= split_qe_r + SEC_W'(1);
      split_us_r  <= US_W'(split_diff_r - SPLIT_W'(US_PER_SEC));
    end else begin
      split_sec_r <= split_qe_r;
      split_us_r  <= US_W'(split_diff_r);
    end
  end

  tetl_ring #(.DEPTH(HUMAN_DEPTH)) u_hum_ring (
    .clk(clk), .rst_n(rst_n), .cmd(hum_cmd), .wr_data(new_stamp),
    .rd_idx(idx_r), .stat(hum_stat), .rd_data(hum_data)
  );

  tetl_ring #(.DEPTH(CAT_DEPTH)) u_cat_ring (
    .clk(clk), .rst_n(rst_n), .cmd(cat_cmd), .wr_data(new_stamp),
    .rd_idx(idx_r), .stat(cat_stat), .rd_data(cat_data)
  );

  assign new_stamp = '{sec: split_sec_r, us: split_us_r};
  assign sel_stat  = ch_r ? cat_stat : hum_stat;
  assign sel_data  = ch_r ? cat_data : hum_data;

  // Throttle: open a new window when the window number grows
  assign new_win = (win_quot > last_win_r[ch_r]);
  assign rec_ok  = new_win || !taken_r[ch_r];

  // Sequence one request and stage its result
  always_comb begin
    state_nxt     = state_r;
    res_ok_nxt    = res_ok_r;
    res_nxt       = res_r;
    last_win_nxt  = last_win_r;
    taken_nxt     = taken_r;
    hum_cmd       = '0;
    cat_cmd       = '0;
    out_valid_nxt = (out_valid_r && !out_ready);
    out_ok_nxt    = out_ok_r;
    out_stamp_nxt = out_stamp_r;
    out_cnt_nxt   = out_cnt_r;
    out_kind_nxt  = out_kind_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept_in) begin
          res_ok_nxt = 1'b0;
          res_nxt    = '0;
          unique case (in_action)
            ACT_RECORD: state_nxt = in_detected ? S_DIV : S_OUT;
            ACT_READ:   state_nxt = S_RD;
            ACT_CLEAR:  state_nxt = S_CLR;
            default:    state_nxt = S_OUT;
          endcase
        end
      end
      S_DIV: begin
        if (win_stat.done) begin
          state_nxt = S_OUT;
          if (new_win) begin
            last_win_nxt[ch_r] = win_quot;
          end
          if (rec_ok) begin
            taken_nxt[ch_r] = 1'b1;
            res_ok_nxt      = 1'b1;
            res_nxt         = new_stamp;
            hum_cmd.wr_en   = !ch_r;
            cat_cmd.wr_en   = ch_r;
          end else begin
            taken_nxt[ch_r] = 1'b1;
          end
        end
      end
      S_RD: begin
        hum_cmd.rd_en = !ch_r;
        cat_cmd.rd_en = ch_r;
        state_nxt     = S_RDW;
      end
      S_RDW: begin
        res_ok_nxt = sel_stat.hit;
        res_nxt    = sel_stat.hit ? sel_data : '0;
        state_nxt  = S_OUT;
      end
      S_CLR: begin
        hum_cmd.clear = 1'b1;
        cat_cmd.clear = 1'b1;
        res_ok_nxt    = 1'b1;
        state_nxt     = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_stamp_nxt = res_r;
          out_cnt_nxt   = sel_stat.count7;
          out_kind_nxt  = ch_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_ok_r    <= out_ok_nxt;
    out_stamp_r <= out_stamp_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_kind_r  <= out_kind_nxt;
  end

  // Window state per channel
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_win_r[0] <= '0;
      last_win_r[1] <= '0;
      taken_r       <= '0;
    end else begin
      last_win_r <= last_win_nxt;
      taken_r    <= taken_nxt;
    end
  end

  // Latch the request fields and the staged result
  always_ff @(posedge clk) begin
    if (accept_in) begin
      ch_r  <= in_channel;
      idx_r <= in_index;
    end
    res_ok_r <= res_ok_nxt;
    res_r    <= res_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_ok           = out_ok_r;
  assign out_seconds      = out_stamp_r.sec;
  assign out_microseconds = out_stamp_r.us;
  assign out_record_count = out_cnt_r;
  assign out_kind         = out_kind_r;

  `ASSERT_IMP(a_idle_divs_quiet, clk, rst_n, in_ready, !win_stat.busy)
  `ASSERT_IMP(a_done_in_div, clk, rst_n, win_stat.done, state_r == S_DIV)
  `ASSERT_NXT(a_out_loaded, clk, rst_n, state_r == S_OUT, state_r == S_OUT || out_valid_r)

endmodule
`default_nettype wire

/* verif/tb_throttled_event_timestamp_log_unit.sv */
`timescale 1ns / 1ps
module tb_throttled_event_timestamp_log_unit;
  import tetl_pkg::*;

  localparam int HUMAN_DEPTH = 64;
  localparam int CAT_DEPTH = 64;
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [2:0] PERIOD_ADDR = {REG_PERIOD, 2'b00};
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS = 10;

  typedef enum int {PACE_SINK_SLOW, PACE_SOURCE_SLOW, PACE_FREE} pace_t;

  typedef struct {
    logic [1:0]        action;
    logic              channel;
    logic              detected;
    logic [TIME_W-1:0] time_us;
    logic [IDX_W-1:0]  idx;
  } log_req_t;

  typedef struct {
    logic                 ok;
    logic [SEC_W-1:0]     seconds;
    logic [US_W-1:0]      micros;
    logic [CNT_OUT_W-1:0] count;
    logic                 kind;
  } log_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  log_req_t drv_req;
  logic out_valid;
  logic out_ready;
  logic out_ok;
  logic [SEC_W-1:0] out_seconds;
  logic [US_W-1:0] out_microseconds;
  logic [CNT_OUT_W-1:0] out_record_count;
  logic out_kind;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  throttled_event_timestamp_log_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_action(drv_req.action),
    .in_channel(drv_req.channel),
    .in_detected(drv_req.detected),
    .in_time_us(drv_req.time_us),
    .in_index(drv_req.idx),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_ok(out_ok),
    .out_seconds(out_seconds),
    .out_microseconds(out_microseconds),
    .out_record_count(out_record_count),
    .out_kind(out_kind),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Log mirror: rings, pointers, counts and window state per channel
  stamp_t ring_mem [2][64];
  int wr_ptr [2];
  int stored [2];
  logic [TIME_W-1:0] last_win [2];
  bit taken [2];
  logic [PERIOD_W-1:0] period_cfg;

  // Request generator bookkeeping: window reached per channel and current time
  logic [TIME_W-1:0] gen_win [2];
  logic [TIME_W-1:0] now_us;

  log_req_t pending_q [$];
  log_result_t expect_q [$];
  pace_t pace;
  bit req_taken;
  int issued_n;
  int accepted_n;
  int cycle_n;
  int errors;
  int n_stored;
  int n_throttled;
  int n_read_hits;
  int n_clears;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Apply one request to the mirror and return the result it must produce
  function automatic log_result_t log_step(input log_req_t q);
    log_result_t res;
    logic [TIME_W-1:0] p;
    logic [TIME_W-1:0] win;
    int ch;
    int d;
    int pos;
    ch = int'(q.channel);
    d = q.channel ? CAT_DEPTH : HUMAN_DEPTH;
    p = (period_cfg == '0) ? TIME_W'(1) : TIME_W'(period_cfg);
    res.ok = 1'b0;
    res.seconds = '0;
    res.micros = '0;
    res.kind = q.channel;
    case (q.action)
      ACT_RECORD: begin
        if (q.detected) begin
          win = q.time_us / p;
          if (win > last_win[ch]) begin
            taken[ch] = 1'b0;
            last_win[ch] = win;
          end
          if (!taken[ch]) begin
            taken[ch] = 1'b1;
            res.seconds = SEC_W'(q.time_us / US_PER_SEC);
            res.micros = US_W'(q.time_us % US_PER_SEC);
            ring_mem[ch][wr_ptr[ch]].sec = res.seconds;
            ring_mem[ch][wr_ptr[ch]].us = res.micros;
            wr_ptr[ch] = (wr_ptr[ch] + 1) % d;
            if (stored[ch] < d) stored[ch]++;
            res.ok = 1'b1;
            n_stored++;
          end else begin
            n_throttled++;
          end
        end
      end
      ACT_READ: begin
        if (int'(q.idx) < stored[ch]) begin
          pos = (wr_ptr[ch] + d - 1 - int'(q.idx)) % d;
          res.seconds = ring_mem[ch][pos].sec;
          res.micros = ring_mem[ch][pos].us;
          res.ok = 1'b1;
          n_read_hits++;
        end
      end
      ACT_CLEAR: begin
        wr_ptr[0] = 0;
        wr_ptr[1] = 0;
        stored[0] = 0;
        stored[1] = 0;
        res.ok = 1'b1;
        n_clears++;
      end
      default: ;
    endcase
    res.count = CNT_OUT_W'(stored[ch]);
    return res;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TIME_W-1:0];
  endfunction

  function automatic logic [63:0] eff_period();
    return (period_cfg == '0) ? 64'd1 : 64'(period_cfg);
  endfunction

  // Pick a time that opens a new window on the channel
  function automatic logic [TIME_W-1:0] fresh_time(input logic ch);
    logic [63:0] p;
    logic [63:0] t;
    p = eff_period();
    t = (64'(gen_win[ch]) + 1) * p;
    if (t < 64'(now_us)) t = 64'(now_us);
    t = t + 64'($urandom_range(0, 32'(p - 1)));
    if (t > 64'(TIME_MAX)) t = 64'(TIME_MAX);
    return t[TIME_W-1:0];
  endfunction

  // Pick a time inside the window the channel already holds
  function automatic logic [TIME_W-1:0] stale_time(input logic ch);
    logic [63:0] p;
    logic [63:0] t;
    p = eff_period();
    t = 64'(gen_win[ch]) * p + 64'($urandom_range(0, 32'(p - 1)));
    if (t > 64'(TIME_MAX)) t = 64'(TIME_MAX);
    return t[TIME_W-1:0];
  endfunction

  // Queue one request and track the windows it opens
  task automatic push_req(input logic [1:0] action, input logic ch, input logic det,
                          input logic [TIME_W-1:0] t, input logic [IDX_W-1:0] idx);
    log_req_t q;
    logic [63:0] w;
    q.action = action;
    q.channel = ch;
    q.detected = det;
    q.time_us = t;
    q.idx = idx;
    if (action == ACT_RECORD && det) begin
      w = 64'(t) / eff_period();
      if (w > 64'(gen_win[ch])) gen_win[ch] = w[TIME_W-1:0];
      if (t > now_us) now_us = t;
    end
    pending_q.push_back(q);
    issued_n++;
  endtask

  // Mostly well-formed records and reads, with some noise mixed in
  task automatic push_random(input bit allow_clear);
    int r;
    logic ch;
    logic [IDX_W-1:0] idx;
    r = $urandom_range(0, 99);
    ch = 1'($urandom_range(0, 1));
    if (r < 55) begin
      push_req(ACT_RECORD, ch, 1'b1, fresh_time(ch), IDX_W'($urandom));
    end else if (r < 62) begin
      push_req(ACT_RECORD, ch, 1'b1, stale_time(ch), IDX_W'($urandom));
    end else if (r < 67) begin
      push_req(ACT_RECORD, ch, 1'b0, rand_time(), IDX_W'($urandom));
    end else if (r < 93) begin
      case ($urandom_range(0, 2))
        0: idx = IDX_W'($urandom_range(0, 7));
        1: idx = IDX_W'($urandom_range(56, 63));
        default: idx = IDX_W'($urandom);
      endcase
      push_req(ACT_READ, ch, 1'($urandom), rand_time(), idx);
    end else if (r < 96 || !allow_clear) begin
      push_req(ACT_UNUSED, ch, 1'($urandom), rand_time(), IDX_W'($urandom));
    end else begin
      push_req(ACT_CLEAR, ch, 1'($urandom), rand_time(), IDX_W'($urandom));
    end
  endtask

  // Hold until every request has been taken and answered
  task automatic wait_idle();
    do @(negedge clk); while (accepted_n != issued_n || expect_q.size() != 0);
  endtask

  // Write the period register: setup cycle, then access cycle
  task automatic write_period(input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= PERIOD_ADDR;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    period_cfg = value;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Driver: present the next request once the previous one is taken
  always @(negedge clk) begin
    logic next_valid;
    bit hold_off;
    next_valid = in_valid && !req_taken;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else if (!next_valid && pending_q.size() != 0) begin
      case (pace)
        PACE_SINK_SLOW: hold_off = ($urandom_range(0, 99) < 20);
        PACE_SOURCE_SLOW: hold_off = ($urandom_range(0, 99) < 85);
        default: hold_off = 1'b0;
      endcase
      if (!hold_off) begin
        drv_req <= pending_q.pop_front();
        next_valid = 1'b1;
      end
    end
    in_valid <= next_valid;
    case (pace)
      PACE_SINK_SLOW: out_ready <= ($urandom_range(0, 99) >= 85);
      PACE_SOURCE_SLOW: out_ready <= ($urandom_range(0, 99) >= 20);
      default: out_ready <= 1'b1;
    endcase
  end

  // Monitor: check each result, then predict for a request taken at this edge
  always @(posedge clk) begin
    log_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expect_q.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("result with no request waiting: ok=%0d s=%0d us=%0d cnt=%0d kind=%0d",
                     out_ok, out_seconds, out_microseconds, out_record_count, out_kind);
        end else begin
          want = expect_q.pop_front();
          if (out_ok !== want.ok || out_seconds !== want.seconds ||
              out_microseconds !== want.micros || out_record_count !== want.count ||
              out_kind !== want.kind) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("mismatch: expected ok=%0d s=%0d us=%0d cnt=%0d kind=%0d, got ok=%0d s=%0d us=%0d cnt=%0d kind=%0d",
                       want.ok, want.seconds, want.micros, want.count, want.kind,
                       out_ok, out_seconds, out_microseconds, out_record_count, out_kind);
          end
        end
      end
      if (in_valid && in_ready) begin
        expect_q.push_back(log_step(drv_req));
        accepted_n <= accepted_n + 1;
      end
      req_taken <= in_valid && in_ready;
    end else begin
      req_taken <= 1'b0;
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_n++;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_n);
      $display("tb_throttled_event_timestamp_log_unit failed");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    drv_req = '{action: ACT_RECORD, channel: 1'b0, detected: 1'b0, time_us: '0, idx: '0};
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    pace = PACE_SINK_SLOW;
    req_taken = 1'b0;
    issued_n = 0;
    accepted_n = 0;
    cycle_n = 0;
    errors = 0;
    n_stored = 0;
    n_throttled = 0;
    n_read_hits = 0;
    n_clears = 0;
    period_cfg = PERIOD_RESET;
    now_us = '0;
    for (int c = 0; c < 2; c++) begin
      wr_ptr[c] = 0;
      stored[c] = 0;
      last_win[c] = '0;
      taken[c] = 1'b0;
      gen_win[c] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: no detection, throttling, read bounds, unused action, clear
    push_req(ACT_RECORD, 1'b0, 1'b0, TIME_MAX, '1);
    push_req(ACT_READ, 1'b0, 1'b1, '0, '0);
    push_req(ACT_RECORD, 1'b0, 1'b1, '0, '0);
    push_req(ACT_RECORD, 1'b0, 1'b1, 48'd499999, '0);
    push_req(ACT_RECORD, 1'b0, 1'b1, 48'd500000, '0);
    push_req(ACT_RECORD, 1'b1, 1'b1, 48'd1999999, '0);
    push_req(ACT_RECORD, 1'b1, 1'b1, 48'd2000000, '0);
    push_req(ACT_READ, 1'b0, 1'b0, TIME_MAX, 6'd0);
    push_req(ACT_READ, 1'b0, 1'b0, '0, 6'd1);
    push_req(ACT_READ, 1'b0, 1'b0, '0, 6'd2);
    push_req(ACT_READ, 1'b1, 1'b1, '0, '1);
    push_req(ACT_READ, 1'b1, 1'b0, '0, 6'd1);
    push_req(ACT_UNUSED, 1'b1, 1'b1, TIME_MAX, '1);
    push_req(ACT_CLEAR, 1'b0, 1'b0, '0, '0);
    push_req(ACT_READ, 1'b1, 1'b0, '0, 6'd0);
    push_req(ACT_RECORD, 1'b1, 1'b1, 48'd2000001, '0);
    push_req(ACT_RECORD, 1'b1, 1'b1, 48'd2500000, '0);
    push_req(ACT_READ, 1'b1, 1'b0, '0, 6'd0);
    wait_idle();

    // Widest window, times in the upper half of the range
    write_period('1);
    if (now_us < 48'h8000_0000_0000) now_us = 48'h8000_0000_0000;
    repeat (130) push_random(1'b0);
    wait_idle();

    // Mid-range window, sender slow
    pace = PACE_SOURCE_SLOW;
    write_period($urandom_range(1000, 2000000));
    repeat (130) push_random(1'b0);
    wait_idle();

    // Shortest window, then zero period, full rate
    pace = PACE_FREE;
    write_period(32'd1);
    repeat (65) push_random(1'b1);
    wait_idle();
    write_period(32'd0);
    repeat (65) push_random(1'b1);
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d requests over periods 500000, max, random, 1 and 0", issued_n);
    $display("%0d events stored, %0d throttled, %0d read hits, %0d clears, %0d mismatches",
             n_stored, n_throttled, n_read_hits, n_clears, errors);
    if (errors == 0 && expect_q.size() == 0) begin
      $display("tb_throttled_event_timestamp_log_unit passed");
    end else begin
      $display("tb_throttled_event_timestamp_log_unit failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/tetl_pkg.sv
rtl/tetl_div.sv
rtl/tetl_ring.sv
rtl/throttled_event_timestamp_log_unit.sv
verif/tb_throttled_event_timestamp_log_unit.sv
